// ===== src/trq_pkg.sv =====
// Types and constants shared by the timed release queue modules.
// Holds the item structs, the table entry struct and the sequencer state type.
package trq_pkg;

  localparam int KEY_W = 48;
  localparam int NOW_W = 47;
  localparam int ID_W  = 16;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_FINAL  = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [NOW_W-1:0] now_us;
    logic [KEY_W-1:0] release_time_us;
    logic [ID_W-1:0]  request_id;
  } in_t;

  typedef struct packed {
    logic            released;
    logic [ID_W-1:0] released_id;
    logic            finished;
    logic            overflow;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic             marker;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_FRONT_RD,
    ST_FRONT_CMP,
    ST_RESP
  } state_t;

endpackage

// ===== src/trq_ram.sv =====
// Entry store of the timed release queue: one write port, one registered read port.
// Depends on trq_pkg for the entry type.
module trq_ram #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  trq_pkg::entry_t       wdata,
  input  logic [AW-1:0]         raddr,
  output trq_pkg::entry_t       rdata
);

  trq_pkg::entry_t mem [DEPTH];
  trq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/timed_release_queue_top.sv =====
// Timed release queue: requests kept in ascending release time, ring-buffered store.
// A tick releases the front entry if due, then checks the front for the final marker; an
// insert scans for its slot, bumping equal keys, shifts later entries up and writes itself.
// Dropped and ignored items and ticks on an empty table go straight to the result. One item
// at a time; the result register lets the next item in while a result waits.
// Synchronous active-low reset empties the table and clears the finished flag.
module timed_release_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  trq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output trq_pkg::out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  trq_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         done_r, done_nxt;
  logic [trq_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [trq_pkg::ID_W-1:0]     id_r, id_nxt;
  logic                         mark_r, mark_nxt;
  logic [trq_pkg::NOW_W-1:0]    now_r, now_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic                         wrap_r, wrap_nxt;
  logic                         rel_r, rel_nxt;
  logic [trq_pkg::ID_W-1:0]     rel_id_r, rel_id_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         out_valid_r, out_valid_nxt;
  trq_pkg::out_t                out_r, out_nxt;

  logic                         in_acc;
  logic                         out_free;
  logic                         is_ins;
  logic [CW-1:0]                rd_log, wr_log;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic                         ram_we;
  trq_pkg::entry_t              ram_wdata, rd_data;

  // logical slot to physical address in the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [SW-1:0] sum;
    sum = SW'(h) + SW'(l);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != trq_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign is_ins   = (in_data.kind == trq_pkg::KIND_INSERT) ||
                    (in_data.kind == trq_pkg::KIND_FINAL);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  trq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // store port controls
  always_comb begin
    rd_log    = '0;
    wr_log    = pos_r;
    ram_we    = 1'b0;
    ram_wdata = '{key: key_r, id: id_r, marker: mark_r};
    case (state_r)
      trq_pkg::ST_SCAN_RD:  rd_log = idx_r;
      trq_pkg::ST_SHIFT_RD: rd_log = idx_r - CW'(1);
      trq_pkg::ST_SHIFT_WR: begin
        wr_log    = idx_r;
        ram_we    = 1'b1;
        ram_wdata = rd_data;
      end
      trq_pkg::ST_PUT: begin
        wr_log = pos_r;
        ram_we = 1'b1;
      end
      default: rd_log = '0;
    endcase
    rd_addr = phys(head_r, rd_log);
    wr_addr = phys(head_r, wr_log);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trq_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (done_r) begin
            state_nxt = trq_pkg::ST_RESP;
          end else if (is_ins) begin
            state_nxt = (count_r == DEPTH_C) ? trq_pkg::ST_RESP : trq_pkg::ST_SCAN_RD;
          end else begin
            state_nxt = (count_r == '0) ? trq_pkg::ST_RESP : trq_pkg::ST_TICK_RD;
          end
        end
      end
      trq_pkg::ST_SCAN_RD: begin
        if (idx_r != count_r) begin
          state_nxt = trq_pkg::ST_SCAN_CMP;
        end else if (!wrap_r) begin
          state_nxt = trq_pkg::ST_SHIFT_RD;
        end
      end
      trq_pkg::ST_SCAN_CMP: begin
        if (rd_data.key > key_r && !wrap_r) begin
          state_nxt = trq_pkg::ST_SHIFT_RD;
        end else begin
          state_nxt = trq_pkg::ST_SCAN_RD;
        end
      end
      trq_pkg::ST_SHIFT_RD: begin
        state_nxt = (idx_r == pos_r) ? trq_pkg::ST_PUT : trq_pkg::ST_SHIFT_WR;
      end
      trq_pkg::ST_SHIFT_WR:  state_nxt = trq_pkg::ST_SHIFT_RD;
      trq_pkg::ST_PUT:       state_nxt = trq_pkg::ST_FRONT_RD;
      trq_pkg::ST_TICK_RD:   state_nxt = trq_pkg::ST_TICK_CMP;
      trq_pkg::ST_TICK_CMP:  state_nxt = trq_pkg::ST_FRONT_RD;
      trq_pkg::ST_FRONT_RD: begin
        state_nxt = (count_r == '0) ? trq_pkg::ST_RESP : trq_pkg::ST_FRONT_CMP;
      end
      trq_pkg::ST_FRONT_CMP: state_nxt = trq_pkg::ST_RESP;
      trq_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = trq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trq_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    key_nxt       = key_r;
    id_nxt        = id_r;
    mark_nxt      = mark_r;
    now_nxt       = now_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    wrap_nxt      = wrap_r;
    rel_nxt       = rel_r;
    rel_id_nxt    = rel_id_r;
    ovf_nxt       = ovf_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      trq_pkg::ST_IDLE: begin
        if (in_acc) begin
          rel_nxt    = 1'b0;
          rel_id_nxt = '0;
          ovf_nxt    = !done_r && is_ins && (count_r == DEPTH_C);
          now_nxt    = in_data.now_us;
          idx_nxt    = '0;
          wrap_nxt   = 1'b0;
          if (in_data.kind == trq_pkg::KIND_FINAL) begin
            key_nxt  = {in_data.now_us, 1'b0};
            id_nxt   = '0;
            mark_nxt = 1'b1;
          end else begin
            key_nxt  = in_data.release_time_us;
            id_nxt   = in_data.request_id;
            mark_nxt = 1'b0;
          end
        end
      end
      trq_pkg::ST_SCAN_RD: begin
        if (idx_r == count_r) begin
          if (wrap_r) begin
            // key wrapped past the top: scan again from the front
            idx_nxt  = '0;
            wrap_nxt = 1'b0;
          end else begin
            pos_nxt = idx_r;
            idx_nxt = count_r;
          end
        end
      end
      trq_pkg::ST_SCAN_CMP: begin
        if (rd_data.key == key_r) begin
          key_nxt = key_r + trq_pkg::KEY_W'(1);
          if (key_r == '1) begin
            wrap_nxt = 1'b1;
          end
          idx_nxt = idx_r + CW'(1);
        end else if (rd_data.key < key_r) begin
          idx_nxt = idx_r + CW'(1);
        end else if (wrap_r) begin
          idx_nxt = count_r;
        end else begin
          pos_nxt = idx_r;
          idx_nxt = count_r;
        end
      end
      trq_pkg::ST_SHIFT_WR: idx_nxt = idx_r - CW'(1);
      trq_pkg::ST_PUT:      count_nxt = count_r + CW'(1);
      trq_pkg::ST_TICK_CMP: begin
        if (!rd_data.marker && rd_data.key < {1'b0, now_r}) begin
          rel_nxt    = 1'b1;
          rel_id_nxt = rd_data.id;
          head_nxt   = (head_r == LAST_C) ? '0 : head_r + AW'(1);
          count_nxt  = count_r - CW'(1);
        end
      end
      trq_pkg::ST_FRONT_CMP: begin
        if (rd_data.marker) begin
          done_nxt = 1'b1;
        end
      end
      trq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{released: rel_r, released_id: rel_id_r,
                            finished: done_r, overflow: ovf_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trq_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    id_r     <= id_nxt;
    mark_r   <= mark_nxt;
    now_r    <= now_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    wrap_r   <= wrap_nxt;
    rel_r    <= rel_nxt;
    rel_id_r <= rel_id_nxt;
    ovf_r    <= ovf_nxt;
    out_r    <= out_nxt;
  end

endmodule
